// ===== rtl/srmp_pkg.sv =====
// ----------------------------------------------------------------------------
// srmp_pkg
// Shared types and constants for the sphere ray-march pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package srmp_pkg;

    // Fixed point: 24 fraction bits
    localparam int FRAC = 24;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int ADDR_W = 12;
    localparam int CHAR_W = 7;
    localparam int CFG_W  = 40;
    localparam int RAD_W  = 39;
    localparam int STEP_W = 10;
    localparam int CFGA_W = 3;

    // Parameter defaults
    localparam int WIDTH_DEF      = 80;
    localparam int HEIGHT_DEF     = 40;
    localparam int COORD_BITS_DEF = 40;

    // Serial divider and root
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;
    localparam int SQ_W      = 64;
    localparam int SQ_ITER   = 32;
    localparam int SQ_CNT_W  = 5;
    localparam int MUL_W     = 32;

    // Marching constants
    localparam logic [63:0] HIT_EPS    = 64'd168;
    localparam logic [63:0] ESC_BOUND  = 64'd167772160000;
    localparam logic [63:0] MAG_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [65:0] TGT_HALF   = 66'd8388608;
    localparam logic [65:0] TGT_Z      = -66'sd25165824;

    localparam logic [CHAR_W-1:0] CHAR_HIT  = 7'd64;
    localparam logic [CHAR_W-1:0] CHAR_MISS = 7'd32;

    // Item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [CFGA_W-1:0] {
        CFG_EYE_X    = 3'd0,
        CFG_EYE_Y    = 3'd1,
        CFG_EYE_Z    = 3'd2,
        CFG_CENTER_X = 3'd3,
        CFG_CENTER_Y = 3'd4,
        CFG_CENTER_Z = 3'd5,
        CFG_RADIUS   = 3'd6,
        CFG_STEPS    = 3'd7
    } t_cfg_addr;

    localparam logic [CFG_W-1:0]  RST_EYE_Z  = -40'sd16777216;
    localparam logic [RAD_W-1:0]  RST_RADIUS = 39'd6710886;
    localparam logic [STEP_W-1:0] RST_STEPS  = 10'd500;

    typedef struct packed {
        logic signed [CFG_W-1:0] eye_x;
        logic signed [CFG_W-1:0] eye_y;
        logic signed [CFG_W-1:0] eye_z;
        logic signed [CFG_W-1:0] center_x;
        logic signed [CFG_W-1:0] center_y;
        logic signed [CFG_W-1:0] center_z;
        logic [RAD_W-1:0]        radius;
        logic [STEP_W-1:0]       max_steps;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [CHAR_W-1:0] char_code;
        logic              hit;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/srmp_front.sv =====
// ----------------------------------------------------------------------------
// srmp_front
// Accepts pixels, forms the frame-buffer address and queues the item.
// ----------------------------------------------------------------------------
`default_nettype none

module srmp_front #(
    parameter int WIDTH = srmp_pkg::WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [srmp_pkg::COL_W-1:0] i_col,
    input  wire logic [srmp_pkg::ROW_W-1:0] i_row,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output srmp_pkg::t_item                 o_item
);

    localparam int AW = 17;

    srmp_pkg::t_item                    r_mem [srmp_pkg::QDEPTH];
    logic [srmp_pkg::QPTR_W-1:0]        r_wr;
    logic [srmp_pkg::QPTR_W-1:0]        r_rd;
    logic [srmp_pkg::QCNT_W-1:0]        r_cnt;
    logic                               push;
    logic                               pop;
    logic [AW-1:0]                      addr_full;
    srmp_pkg::t_item                    item;

    assign o_ready = (r_cnt != srmp_pkg::QCNT_W'(srmp_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    // address is col + row * WIDTH, truncated to the 12-bit address width
    assign addr_full = AW'(i_col) + AW'(i_row) * AW'(WIDTH);
    always_comb begin
        item.addr = addr_full[srmp_pkg::ADDR_W-1:0];
        item.col  = i_col;
        item.row  = i_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= item;
    end

endmodule

`default_nettype wire

// ===== rtl/srmp_div.sv =====
// ----------------------------------------------------------------------------
// srmp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srmp_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [srmp_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [srmp_pkg::DIV_DEN_W-1:0] i_den,
    output logic                                o_done,
    output logic [srmp_pkg::DIV_DEN_W-1:0]      o_quo
);

    localparam int NW = srmp_pkg::DIV_NUM_W;
    localparam int DW = srmp_pkg::DIV_DEN_W;

    logic                             r_busy;
    logic                             r_done;
    logic [srmp_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [NW-1:0]                    r_num;
    logic [DW-1:0]                    r_den;
    logic [DW-1:0]                    r_rem;
    logic [DW-1:0]                    r_quo;
    logic [DW:0]                      trial;
    logic                             ge;
    logic [DW:0]                      diff;
    logic                             last;

    assign trial = {r_rem, r_num[NW-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};
    assign last  = (r_cnt == srmp_pkg::DIV_CNT_W'(NW - 1));
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start)   r_busy <= 1'b1;
            else if (last) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srmp_sqrt.sv =====
// ----------------------------------------------------------------------------
// srmp_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srmp_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [srmp_pkg::SQ_W-1:0]  i_x,
    output logic                            o_done,
    output logic [srmp_pkg::SQ_W/2-1:0]     o_root
);

    localparam int W = srmp_pkg::SQ_W;

    logic                            r_busy;
    logic                            r_done;
    logic [srmp_pkg::SQ_CNT_W-1:0]   r_cnt;
    logic [W-1:0]                    r_x;
    logic [W-1:0]                    r_res;
    logic [W-1:0]                    r_bit;
    logic [W-1:0]                    cand;
    logic                            take;
    logic                            last;

    assign cand   = r_res + r_bit;
    assign take   = (r_x >= cand);
    assign last   = (r_cnt == srmp_pkg::SQ_CNT_W'(srmp_pkg::SQ_ITER - 1));
    assign o_done = r_done;
    assign o_root = r_res[W/2-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start)   r_busy <= 1'b1;
            else if (last) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= W'(1) << (W - 2);
            r_cnt <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_x   <= r_x - cand;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srmp_engine.sv =====
// ----------------------------------------------------------------------------
// srmp_engine
// Back end: ray set-up, normalisation and the sphere-tracing loop.
// ----------------------------------------------------------------------------
`default_nettype none

module srmp_engine #(
    parameter int WIDTH  = srmp_pkg::WIDTH_DEF,
    parameter int HEIGHT = srmp_pkg::HEIGHT_DEF,
    parameter int CB     = srmp_pkg::COORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  srmp_pkg::t_cfg   i_cfg,
    input  wire logic        i_item_valid,
    output logic             o_item_ready,
    input  srmp_pkg::t_item  i_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output srmp_pkg::t_result o_out
);

    localparam logic signed [65:0] C_HI = (66'sd1 <<< (CB - 1)) - 66'sd1;
    localparam logic signed [65:0] C_LO = -C_HI - 66'sd1;
    localparam logic signed [CB-1:0] HIT_CB = CB'(srmp_pkg::HIT_EPS);
    localparam int DMW = srmp_pkg::FRAC + 1;

    // floor((v << 24) / N) = (v * ceil(2^41 / N)) >> 17, exact for v below 128
    localparam int          RCP_K  = 41;
    localparam int          RCP_SH = RCP_K - srmp_pkg::FRAC;
    localparam logic [40:0] RCP_X  =
        41'(((64'd1 << RCP_K) + 64'(WIDTH) - 64'd1) / 64'(WIDTH));
    localparam logic [40:0] RCP_Y  =
        41'(((64'd1 << RCP_K) + 64'(HEIGHT) - 64'd1) / 64'(HEIGHT));

    typedef enum logic [17:0] {
        ST_IDLE   = 18'h00001,
        ST_TGT_X  = 18'h00002,
        ST_TGT_Y  = 18'h00004,
        ST_NORM   = 18'h00008,
        ST_SQ_MUL = 18'h00010,
        ST_SQ_ACC = 18'h00020,
        ST_SQRT   = 18'h00040,
        ST_NDIV   = 18'h00080,
        ST_LOOP   = 18'h00100,
        ST_LSHIFT = 18'h00200,
        ST_LSAT   = 18'h00400,
        ST_DIST   = 18'h00800,
        ST_CHECK  = 18'h01000,
        ST_MUL_H  = 18'h02000,
        ST_MUL_L  = 18'h04000,
        ST_MAG    = 18'h08000,
        ST_UPD    = 18'h10000,
        ST_DONE   = 18'h20000
    } t_state;

    function automatic logic signed [CB-1:0] f_clamp(input logic signed [65:0] v);
        logic signed [CB-1:0] r;
        if (v > C_HI)      r = C_HI[CB-1:0];
        else if (v < C_LO) r = C_LO[CB-1:0];
        else               r = v[CB-1:0];
        return r;
    endfunction

    function automatic logic [CB-1:0] f_mag(input logic signed [CB-1:0] v);
        logic [CB-1:0] r;
        r = v[CB-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    t_state                         r_state;
    t_state                         n_state;
    srmp_pkg::t_item                r_item;
    logic signed [CB-1:0]           r_p    [3];
    logic [CB-1:0]                  r_mag  [3];
    logic                           r_rneg [3];
    logic [DMW-1:0]                 r_dmag [3];
    logic                           r_dneg [3];
    logic [63:0]                    r_sum;
    logic [63:0]                    r_prod;
    logic [63:0]                    r_ph;
    logic [31:0]                    r_len;
    logic [5:0]                     r_s;
    logic [63:0]                    r_lsh;
    logic signed [CB-1:0]           r_d;
    logic [63:0]                    r_mv;
    logic [1:0]                     r_k;
    logic [srmp_pkg::STEP_W-1:0]    r_i;
    logic                           r_lenmode;
    logic                           r_hit;
    logic                           r_out_valid;
    logic                           n_out_valid;
    srmp_pkg::t_result              r_out;

    logic                           load_out;
    logic [1:0]                     k_nx;
    logic [CB-1:0]                  mx;
    logic                           big;
    logic                           tiny;
    logic [63:0]                    ud;
    logic                           d_neg;
    logic [31:0]                    op_a;
    logic [31:0]                    op_b;
    logic [63:0]                    prod;
    logic                           div_start;
    logic [srmp_pkg::DIV_NUM_W-1:0] div_num;
    logic [srmp_pkg::DIV_DEN_W-1:0] div_den;
    logic                           div_done;
    logic [srmp_pkg::DIV_DEN_W-1:0] div_quo;
    logic                           sq_start;
    logic [63:0]                    sq_x;
    logic                           sq_done;
    logic [31:0]                    sq_root;
    logic [47:0]                    tx_prod;
    logic [47:0]                    ty_prod;
    logic [30:0]                    tq;
    logic signed [65:0]             tgt;
    logic signed [CB-1:0]           ray_xy;
    logic signed [CB-1:0]           ray_z;
    logic signed [CB-1:0]           eye_c  [3];
    logic signed [CB-1:0]           ctr_c  [3];
    logic signed [CB-1:0]           dif_c  [3];
    logic                           esc;
    logic [95:0]                    lwide;
    logic [64:0]                    mv_sum;
    logic                           step_neg;
    logic signed [65:0]             upd;

    assign eye_c[0] = f_clamp(66'($signed(i_cfg.eye_x)));
    assign eye_c[1] = f_clamp(66'($signed(i_cfg.eye_y)));
    assign eye_c[2] = f_clamp(66'($signed(i_cfg.eye_z)));
    assign ctr_c[0] = f_clamp(66'($signed(i_cfg.center_x)));
    assign ctr_c[1] = f_clamp(66'($signed(i_cfg.center_y)));
    assign ctr_c[2] = f_clamp(66'($signed(i_cfg.center_z)));

    always_comb begin
        for (int k = 0; k < 3; k++) dif_c[k] = f_clamp(66'(r_p[k]) - 66'(ctr_c[k]));
    end

    assign k_nx = r_k + 2'd1;

    always_comb begin
        mx = r_mag[0];
        if (r_mag[1] > mx) mx = r_mag[1];
        if (r_mag[2] > mx) mx = r_mag[2];
    end
    assign big  = (mx[CB-1:31] != '0);
    assign tiny = (mx[CB-1:30] == '0);

    assign ud    = 64'(f_mag(r_d));
    assign d_neg = r_d[CB-1];

    // target minus eye, x from the column quotient and y from the row quotient
    assign tx_prod = 48'(r_item.col) * 48'(RCP_X);
    assign ty_prod = 48'(r_item.row) * 48'(RCP_Y);
    assign tq      = (r_state == ST_TGT_X) ? tx_prod[47:RCP_SH] : ty_prod[47:RCP_SH];
    assign tgt     = $signed(66'(tq)) - $signed(srmp_pkg::TGT_HALF);
    assign ray_xy  = f_clamp(tgt - 66'((r_state == ST_TGT_X) ? r_p[0] : r_p[1]));
    assign ray_z   = f_clamp($signed(srmp_pkg::TGT_Z) - 66'(r_p[2]));

    assign esc = (64'(f_mag(r_p[0])) > srmp_pkg::ESC_BOUND) ||
                 (64'(f_mag(r_p[1])) > srmp_pkg::ESC_BOUND) ||
                 (64'(f_mag(r_p[2])) > srmp_pkg::ESC_BOUND);

    assign lwide  = 96'(r_len) << r_s;
    assign mv_sum = 65'(r_ph << 8) + 65'(r_prod >> srmp_pkg::FRAC);

    assign step_neg = r_dneg[r_k] ^ d_neg;
    assign upd = step_neg ? (66'(r_p[r_k]) + 66'(r_mv)) : (66'(r_p[r_k]) - 66'(r_mv));

    // one shared multiplier: squares for the length, dir times distance for the step
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            ST_SQ_MUL: begin
                op_a = 32'(r_mag[r_k][30:0]);
                op_b = 32'(r_mag[r_k][30:0]);
            end
            ST_MUL_H: begin
                op_a = ud[63:32];
                op_b = 32'(r_dmag[r_k]);
            end
            ST_MUL_L: begin
                op_a = ud[31:0];
                op_b = 32'(r_dmag[r_k]);
            end
            default: begin
                op_a = '0;
            end
        endcase
    end
    assign prod = 64'(op_a) * 64'(op_b);

    assign sq_x = r_sum + r_prod;

    // control
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) n_state = ST_TGT_X;
            end
            ST_TGT_X: n_state = ST_TGT_Y;
            ST_TGT_Y: n_state = ST_NORM;
            ST_NORM: begin
                if (mx == '0)   n_state = ST_LOOP;
                else if (!big && !tiny) n_state = ST_SQ_MUL;
            end
            ST_SQ_MUL: n_state = ST_SQ_ACC;
            ST_SQ_ACC: begin
                if (r_k == 2'd2) begin
                    sq_start = 1'b1;
                    n_state  = ST_SQRT;
                end else begin
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    if (r_lenmode) begin
                        n_state = ST_LSAT;
                    end else begin
                        div_start = 1'b1;
                        div_num   = srmp_pkg::DIV_NUM_W'(r_mag[0][30:0]) << srmp_pkg::FRAC;
                        div_den   = sq_root;
                        n_state   = ST_NDIV;
                    end
                end
            end
            ST_NDIV: begin
                if (div_done) begin
                    if (r_k == 2'd2) begin
                        n_state = ST_LOOP;
                    end else begin
                        div_start = 1'b1;
                        div_num   = srmp_pkg::DIV_NUM_W'(r_mag[k_nx][30:0]) << srmp_pkg::FRAC;
                        div_den   = r_len;
                    end
                end
            end
            ST_LOOP: begin
                if (r_i >= i_cfg.max_steps) n_state = ST_DONE;
                else                        n_state = ST_LSHIFT;
            end
            ST_LSHIFT: begin
                if (!big) n_state = ST_SQ_MUL;
            end
            ST_LSAT:  n_state = ST_DIST;
            ST_DIST:  n_state = ST_CHECK;
            ST_CHECK: begin
                if (esc || (r_d < HIT_CB)) n_state = ST_DONE;
                else                       n_state = ST_MUL_H;
            end
            ST_MUL_H: n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MAG;
            ST_MAG:   n_state = ST_UPD;
            ST_UPD: begin
                if (r_k == 2'd2) n_state = ST_LOOP;
                else             n_state = ST_MUL_H;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid  = load_out || (r_out_valid && !i_out_ready);
    assign o_item_ready = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.pixel_address <= r_item.addr;
            r_out.char_code     <= r_hit ? srmp_pkg::CHAR_HIT : srmp_pkg::CHAR_MISS;
            r_out.hit           <= r_hit;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_item <= i_item;
                r_i    <= '0;
                r_hit  <= 1'b0;
                for (int k = 0; k < 3; k++) r_p[k] <= eye_c[k];
            end
            ST_TGT_X: begin
                r_mag[0]  <= f_mag(ray_xy);
                r_rneg[0] <= ray_xy[CB-1];
            end
            ST_TGT_Y: begin
                r_mag[1]  <= f_mag(ray_xy);
                r_rneg[1] <= ray_xy[CB-1];
                r_mag[2]  <= f_mag(ray_z);
                r_rneg[2] <= ray_z[CB-1];
            end
            ST_NORM: begin
                // bring the largest magnitude into [2^30, 2^31)
                if (mx == '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_dmag[k] <= '0;
                        r_dneg[k] <= 1'b0;
                    end
                end else if (big) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                end else if (tiny) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                end else begin
                    r_sum     <= '0;
                    r_k       <= '0;
                    r_lenmode <= 1'b0;
                end
            end
            ST_SQ_MUL: r_prod <= prod;
            ST_SQ_ACC: begin
                r_sum <= sq_x;
                r_k   <= k_nx;
            end
            ST_SQRT: begin
                if (sq_done) begin
                    r_len <= sq_root;
                    r_k   <= '0;
                end
            end
            ST_NDIV: begin
                if (div_done) begin
                    r_dmag[r_k] <= div_quo[DMW-1:0];
                    r_dneg[r_k] <= r_rneg[r_k];
                    r_k         <= k_nx;
                end
            end
            ST_LOOP: begin
                for (int k = 0; k < 3; k++) r_mag[k] <= f_mag(dif_c[k]);
                r_s <= '0;
            end
            ST_LSHIFT: begin
                if (big) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                    r_s <= r_s + 1'b1;
                end else begin
                    r_sum     <= '0;
                    r_k       <= '0;
                    r_lenmode <= 1'b1;
                end
            end
            ST_LSAT: r_lsh <= (lwide[95:63] != '0) ? srmp_pkg::MAG_MAX : lwide[63:0];
            ST_DIST: begin
                r_d <= f_clamp($signed(66'(r_lsh) - 66'(i_cfg.radius)));
            end
            ST_CHECK: begin
                r_hit <= !esc && (r_d < HIT_CB);
                r_k   <= '0;
            end
            ST_MUL_H: r_prod <= prod;
            ST_MUL_L: begin
                r_ph   <= r_prod;
                r_prod <= prod;
            end
            ST_MAG: begin
                if (r_ph[63:55] != '0)                r_mv <= srmp_pkg::MAG_MAX;
                else if (mv_sum > 65'(srmp_pkg::MAG_MAX)) r_mv <= srmp_pkg::MAG_MAX;
                else                                  r_mv <= mv_sum[63:0];
            end
            ST_UPD: begin
                r_p[r_k] <= f_clamp(upd);
                r_k      <= k_nx;
                if (r_k == 2'd2) r_i <= r_i + 1'b1;
            end
            ST_DONE: begin
                r_k <= '0;
            end
            default: begin
                r_k <= '0;
            end
        endcase
    end

    srmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    srmp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

endmodule

`default_nettype wire

// ===== rtl/sphere_ray_march_pixel_top.sv =====
// ----------------------------------------------------------------------------
// sphere_ray_march_pixel_top
// Sphere-traces one pixel against one sphere and returns its character.
// ----------------------------------------------------------------------------
// A pixel enters on the slave stream and is queued (two deep) by the front
// end; the back end then works on one pixel at a time. Set-up forms the
// target from constant reciprocal multiplies, then runs the normalising
// shift (one bit per step), a serial square root and three serial divides
// for the direction. Each marching step is mostly the serial square root,
// plus a shift step for every bit by which the point-to-centre vector
// exceeds 31 bits. One finished result waits in the output register while
// the next pixel is marched.
`default_nettype none

module sphere_ray_march_pixel_top #(
    parameter int WIDTH      = srmp_pkg::WIDTH_DEF,
    parameter int HEIGHT     = srmp_pkg::HEIGHT_DEF,
    parameter int COORD_BITS = srmp_pkg::COORD_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [6:0] column, [12:7] row, [15:13] zero
    input  wire logic [15:0]                 s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [11:0] pixel_address, [18:12] char_code, [19] hit, [23:20] zero
    output logic [23:0]                      m_axis_tdata,
    input  wire logic                        i_cfg_we,
    input  wire logic [srmp_pkg::CFGA_W-1:0] i_cfg_addr,
    input  wire logic [srmp_pkg::CFG_W-1:0]  i_cfg_data
);

    srmp_pkg::t_cfg    r_cfg;
    srmp_pkg::t_item   q_item;
    srmp_pkg::t_result res;
    logic              q_valid;
    logic              q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eye_x     <= '0;
            r_cfg.eye_y     <= '0;
            r_cfg.eye_z     <= srmp_pkg::RST_EYE_Z;
            r_cfg.center_x  <= '0;
            r_cfg.center_y  <= '0;
            r_cfg.center_z  <= '0;
            r_cfg.radius    <= srmp_pkg::RST_RADIUS;
            r_cfg.max_steps <= srmp_pkg::RST_STEPS;
        end else if (i_cfg_we) begin
            unique case (srmp_pkg::t_cfg_addr'(i_cfg_addr))
                srmp_pkg::CFG_EYE_X:    r_cfg.eye_x    <= i_cfg_data;
                srmp_pkg::CFG_EYE_Y:    r_cfg.eye_y    <= i_cfg_data;
                srmp_pkg::CFG_EYE_Z:    r_cfg.eye_z    <= i_cfg_data;
                srmp_pkg::CFG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                srmp_pkg::CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                srmp_pkg::CFG_CENTER_Z: r_cfg.center_z <= i_cfg_data;
                srmp_pkg::CFG_RADIUS:   r_cfg.radius   <= i_cfg_data[srmp_pkg::RAD_W-1:0];
                srmp_pkg::CFG_STEPS:    r_cfg.max_steps <= i_cfg_data[srmp_pkg::STEP_W-1:0];
                default:                r_cfg.max_steps <= r_cfg.max_steps;
            endcase
        end
    end

    srmp_front #(
        .WIDTH (WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_col   (s_axis_tdata[6:0]),
        .i_row   (s_axis_tdata[12:7]),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    srmp_engine #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .CB     (COORD_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out        (res)
    );

    assign m_axis_tdata = {4'b0, res.hit, res.char_code, res.pixel_address};

endmodule

`default_nettype wire

// ===== rtl/srmp_checker.sv =====
// ----------------------------------------------------------------------------
// srmp_checker
// Port-level checks on the sphere ray-march pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

module srmp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic [15:0]                 s_axis_tdata,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [23:0]                 m_axis_tdata,
    input wire logic                        i_cfg_we,
    input wire logic [srmp_pkg::CFGA_W-1:0] i_cfg_addr,
    input wire logic [srmp_pkg::CFG_W-1:0]  i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_char_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[19] && m_axis_tdata[18:12] == srmp_pkg::CHAR_HIT) ||
                          (!m_axis_tdata[19] && m_axis_tdata[18:12] == srmp_pkg::CHAR_MISS))
        else $error("character does not match hit flag");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:20] == 4'b0)
        else $error("result padding not zero");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat straight after reset");

endmodule

bind sphere_ray_march_pixel_top srmp_checker u_srmp_checker (.*);

`default_nettype wire

// ===== dv/tb_sphere_ray_march_pixel_top.sv =====
// ----------------------------------------------------------------------------
// tb_sphere_ray_march_pixel_top
// Self-checking bench for the sphere ray-march pixel block: pixels are fed
// through the slave stream in random bursts, the outcome of each one is
// marched out independently in fixed point and compared field by field with
// the master stream beats, across a series of sphere and eye settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sphere_ray_march_pixel_top;

    import srmp_pkg::*;

    localparam int          PIX_W      = 80;
    localparam int          PIX_H      = 40;
    localparam longint      COORD_HI   = (64'sd1 <<< 39) - 1;
    localparam longint      COORD_LO   = -(64'sd1 <<< 39);
    localparam logic [63:0] ROOT_LIM   = 64'd1 << 31;
    localparam int          IDLE_LIMIT = 500000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFGA_W-1:0]    i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    sphere_ray_march_pixel_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Scene settings as the block should hold them
    longint      eye_pos [3];
    longint      ctr_pos [3];
    longint      radius_q24;
    logic [9:0]  step_limit;

    logic [15:0] pixel_q [$];
    t_result     pixel_result_q [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    logic        in_taken = 1'b0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          stall_left = 0;
    logic        rx_calm = 1'b1;
    logic        tx_calm = 1'b1;

    function automatic longint sat_coord(longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic logic [63:0] magn(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] dist_len(longint v [3]);
        logic [63:0] a [3];
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] len;
        int          s;
        m = 0;
        sum = 0;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            a[k] = magn(v[k]);
            if (a[k] > m) m = a[k];
        end
        while ((m >> s) >= ROOT_LIM) s++;
        for (int k = 0; k < 3; k++) sum += (a[k] >> s) * (a[k] >> s);
        len = root64(sum);
        if (s > 0) begin
            if (len > (MAG_MAX >> s)) return MAG_MAX;
            len = len << s;
        end
        return len;
    endfunction

    // Truncate the magnitude of dir*d toward zero, then restore the sign
    function automatic longint scale_step(longint dir, longint d);
        logic [63:0] ur;
        logic [63:0] ud;
        logic [63:0] ph;
        logic [63:0] pl;
        logic [63:0] r;
        ur = magn(dir);
        ud = magn(d);
        ph = (ud >> 32) * ur;
        pl = (ud & 64'hFFFF_FFFF) * ur;
        r = (ph >= (64'd1 << 55)) ? MAG_MAX : (ph << 8) + (pl >> FRAC);
        if (r > MAG_MAX) r = MAG_MAX;
        return ((dir < 0) != (d < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_result march_pixel(logic [6:0] col, logic [5:0] row);
        longint      p [3];
        longint      ray [3];
        longint      dir [3];
        longint      diff [3];
        longint      tgt [3];
        logic [63:0] a [3];
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] len;
        longint      d;
        logic        hit;
        t_result     r;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) p[k] = sat_coord(eye_pos[k]);
        tgt[0] = longint'((64'(col) << FRAC) / PIX_W) - (64'sd1 <<< (FRAC - 1));
        tgt[1] = longint'((64'(row) << FRAC) / PIX_H) - (64'sd1 <<< (FRAC - 1));
        tgt[2] = -25165824;
        for (int k = 0; k < 3; k++) ray[k] = sat_coord(sat_coord(tgt[k]) - p[k]);

        // Normalise: bring the largest magnitude into [2^30, 2^31)
        m = 0;
        for (int k = 0; k < 3; k++) begin
            a[k] = magn(ray[k]);
            if (a[k] > m) m = a[k];
        end
        if (m == 0) begin
            for (int k = 0; k < 3; k++) dir[k] = 0;
        end else begin
            while (m >= ROOT_LIM) begin
                m = m >> 1;
                for (int k = 0; k < 3; k++) a[k] = a[k] >> 1;
            end
            while (m < (ROOT_LIM >> 1)) begin
                m = m << 1;
                for (int k = 0; k < 3; k++) a[k] = a[k] << 1;
            end
            sum = 0;
            for (int k = 0; k < 3; k++) sum += a[k] * a[k];
            len = root64(sum);
            for (int k = 0; k < 3; k++) begin
                dir[k] = longint'((a[k] << FRAC) / len);
                if (ray[k] < 0) dir[k] = -dir[k];
            end
        end

        for (int i = 0; i < step_limit; i++) begin
            for (int k = 0; k < 3; k++) diff[k] = sat_coord(p[k] - sat_coord(ctr_pos[k]));
            d = sat_coord(longint'(dist_len(diff)) - radius_q24);
            if (magn(p[0]) > ESC_BOUND || magn(p[1]) > ESC_BOUND || magn(p[2]) > ESC_BOUND)
                break;
            if (d < longint'(HIT_EPS)) begin
                hit = 1'b1;
                break;
            end
            for (int k = 0; k < 3; k++) p[k] = sat_coord(p[k] - scale_step(dir[k], d));
        end

        r.pixel_address = 12'(32'(col) + 32'(row) * PIX_W);
        r.char_code = hit ? CHAR_HIT : CHAR_MISS;
        r.hit = hit;
        return r;
    endfunction

    // Sender: bursts of beats separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                s_axis_tdata <= pixel_q.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 6);
                    if (tx_calm)
                        gap_left <= 0;
                    else if ($urandom_range(0, 3) == 0)
                        gap_left <= $urandom_range(50, 3000);
                    else
                        gap_left <= $urandom_range(0, 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls of random length, short and long
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 7) == 0)
                stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 800)
                                                          : $urandom_range(1, 5);
        end
    end

    // Predict on input beats, check output beats, watch for a hang
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                pixel_result_q.push_back(march_pixel(s_axis_tdata[6:0], s_axis_tdata[12:7]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.pixel_address = m_axis_tdata[11:0];
                got.char_code = m_axis_tdata[18:12];
                got.hit = m_axis_tdata[19];
                if (pixel_result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: addr %0d char %0d hit %0d",
                                 got.pixel_address, got.char_code, got.hit);
                end else begin
                    exp_r = pixel_result_q.pop_front();
                    if (got != exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp addr %0d char %0d hit %0d, got %0d %0d %0d",
                                     exp_r.pixel_address, exp_r.char_code, exp_r.hit,
                                     got.pixel_address, got.char_code, got.hit);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (pixel_q.size() > 0 || s_axis_tvalid || pixel_result_q.size() > 0)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sphere_ray_march_pixel_top regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(t_cfg_addr idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_EYE_X:    eye_pos[0] = longint'($signed(val));
            CFG_EYE_Y:    eye_pos[1] = longint'($signed(val));
            CFG_EYE_Z:    eye_pos[2] = longint'($signed(val));
            CFG_CENTER_X: ctr_pos[0] = longint'($signed(val));
            CFG_CENTER_Y: ctr_pos[1] = longint'($signed(val));
            CFG_CENTER_Z: ctr_pos[2] = longint'($signed(val));
            CFG_RADIUS:   radius_q24 = longint'(val[RAD_W-1:0]);
            CFG_STEPS:    step_limit = val[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_scene(logic [39:0] ex, logic [39:0] ey, logic [39:0] ez,
                             logic [39:0] cx, logic [39:0] cy, logic [39:0] cz,
                             logic [39:0] rad, logic [39:0] steps);
        write_reg(CFG_EYE_X, ex);
        write_reg(CFG_EYE_Y, ey);
        write_reg(CFG_EYE_Z, ez);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_STEPS, steps);
    endtask

    task automatic add_pixel(int col, int row);
        pixel_q.push_back({3'b000, 6'(row), 7'(col)});
    endtask

    task automatic add_random_pixels(int n);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0)
                add_pixel($urandom_range(0, 127), $urandom_range(0, 63));
            else
                add_pixel($urandom_range(0, PIX_W - 1), $urandom_range(0, PIX_H - 1));
        end
    endtask

    // Hold until every pixel has gone in and every result has come out
    task automatic drain();
        do @(posedge i_clk);
        while (pixel_q.size() > 0 || s_axis_tvalid || pixel_result_q.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    // Small random offset around zero, in Q.24
    function automatic logic [39:0] near(int span_q24);
        return 40'($signed($urandom_range(0, 2 * span_q24)) - span_q24);
    endfunction

    initial begin
        eye_pos = '{0, 0, -16777216};
        ctr_pos = '{0, 0, 0};
        radius_q24 = 6710886;
        step_limit = 10'd500;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset scene: corners, centre, out-of-range indices
        add_pixel(0, 0);   add_pixel(79, 0);  add_pixel(0, 39);   add_pixel(79, 39);
        add_pixel(40, 20); add_pixel(38, 19); add_pixel(44, 24);  add_pixel(127, 63);
        add_pixel(127, 0); add_pixel(0, 63);  add_pixel(85, 5);   add_pixel(10, 45);
        drain();

        // No steps at all
        set_scene(0, 0, 40'h00_FF00_0000, 0, 0, 0, 6710886, 0);
        add_pixel(40, 20); add_pixel(3, 7);
        drain();

        // Single step; eye on the target line gives a zero ray
        set_scene(0, 0, 40'(-25165824), 0, 0, 40'(-25165824), 0, 1);
        add_pixel(40, 20); add_pixel(0, 0); add_pixel(79, 39);
        drain();

        // Coordinate extremes: escape at once
        set_scene(40'h80_0000_0000, 40'h7F_FFFF_FFFF, 40'h80_0000_0000,
                  40'h7F_FFFF_FFFF, 40'h80_0000_0000, 40'h7F_FFFF_FFFF,
                  40'h7F_FFFF_FFFF, 1023);
        add_pixel(0, 0); add_pixel(79, 39);
        drain();

        // Longest step budget on the default sphere
        set_scene(0, 0, 40'(-16777216), 0, 0, 0, 6710886, 1023);
        add_pixel(40, 20); add_pixel(30, 25);
        drain();

        // Random values in every register, radius top bit held at zero
        set_scene({$urandom(), 8'($urandom())}, {$urandom(), 8'($urandom())},
                  {$urandom(), 8'($urandom())}, {$urandom(), 8'($urandom())},
                  {$urandom(), 8'($urandom())}, {$urandom(), 8'($urandom())},
                  {1'b0, $urandom(), 7'($urandom())}, 10'($urandom()));
        add_random_pixels(6);
        drain();

        // Random scenes near the origin with short step budgets
        for (int ph = 0; ph < 6; ph++) begin
            tx_calm = (ph == 0);
            rx_calm = (ph == 0) || (ph == 3);
            set_scene(near(1 << 23), near(1 << 23), 40'(-16777216) + near(1 << 24),
                      near(1 << 23), near(1 << 23), near(1 << 24),
                      40'($urandom_range(0, 1 << 24)), $urandom_range(1, 60));
            add_random_pixels(14);
            drain();
        end

        if (mismatches == 0)
            $display("sphere_ray_march_pixel_top regression: pass");
        else
            $display("sphere_ray_march_pixel_top regression: fail");
        $finish;
    end

endmodule
